### src/pci_pkg.sv
package pci_pkg;

    localparam int SINE_TABLE_BITS_DEF = 10;

    localparam logic [15:0] ANGLE_THIRD = 16'd21845;

    // odd quarter-wave sine polynomial, Q2.30
    localparam logic [31:0] C1 = 32'd1686629713;
    localparam logic [31:0] C3 = 32'd693598668;
    localparam logic [31:0] C5 = 32'd85569306;
    localparam logic [31:0] C7 = 32'd5026995;

    // divide by three: ceil(2^33 / 3), exact for operands up to 2^32
    localparam logic [31:0] RECIP3 = 32'hAAAAAAAB;
    // floor(2^32 / 3); 2^32 leaves remainder 1
    localparam logic [33:0] THIRD_OF_2P32 = 34'd1431655765;

    localparam logic [1:0] REG_POLE_PAIRS = 2'd0;
    localparam logic [1:0] REG_RESISTANCE = 2'd1;
    localparam logic [1:0] REG_INDUCTANCE = 2'd2;
    localparam logic [1:0] REG_EMF_CONST  = 2'd3;

    localparam int DIV_Q_W = 34;

    localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
    localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

    typedef struct packed {
        logic signed [31:0] terminal_volt_a;
        logic signed [31:0] terminal_volt_b;
        logic signed [31:0] terminal_volt_c;
        logic signed [31:0] rotor_speed;
        logic        [15:0] rotor_angle;
        logic        [31:0] time_step;
    } t_in;

    typedef struct packed {
        logic signed [31:0] current_a;
        logic signed [31:0] current_b;
        logic signed [31:0] current_c;
        logic signed [31:0] emf_a;
        logic signed [31:0] emf_b;
        logic signed [31:0] emf_c;
        logic signed [31:0] neutral_volt_a;
        logic signed [31:0] neutral_volt_b;
        logic signed [31:0] neutral_volt_c;
        logic               held;
    } t_out;

    typedef struct packed {
        logic busy;
        logic done;
        logic ovf;
    } t_div_stat;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > SAT_MAX) begin
            return 32'sh7FFFFFFF;
        end else if (v < SAT_MIN) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] signed_sat(input logic neg, input logic [47:0] mag);
        if (!neg) begin
            return (mag > 48'h7FFFFFFF) ? 32'sh7FFFFFFF : mag[31:0];
        end
        return (mag >= 48'h80000000) ? 32'sh80000000 : 32'(-mag[31:0]);
    endfunction

endpackage

### src/pci_if.sv
interface pci_in_if;
    import pci_pkg::*;
    logic valid;
    logic ready;
    t_in  data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface pci_out_if;
    import pci_pkg::*;
    logic valid;
    logic ready;
    t_out data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### src/pci_mul.sv
module pci_mul (
    input  logic        i_clk,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [63:0] o_prod
);
    logic [63:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= 64'(i_a) * 64'(i_b);
    end

    assign o_prod = r_prod;
endmodule

### src/pci_div.sv
module pci_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [63:0]                i_num,
    input  logic [31:0]                i_den,
    output logic [pci_pkg::DIV_Q_W-1:0] o_quot,
    output pci_pkg::t_div_stat         o_stat
);
    import pci_pkg::*;

    logic [31:0]        r_rem;
    logic [DIV_Q_W-1:0] r_nq;
    logic [5:0]         r_cnt;
    logic               r_busy;
    logic               r_done;
    logic               r_ovf;
    logic [32:0]        trial;
    logic               ge;

    // restoring, one quotient bit a cycle; numerator bits above the
    // quotient width seed the remainder and feed the overflow flag
    assign trial = {r_rem, r_nq[DIV_Q_W-1]};
    assign ge    = (trial >= {1'b0, i_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem  <= 32'(i_num[63:DIV_Q_W]);
                r_nq   <= i_num[DIV_Q_W-1:0];
                r_ovf  <= (32'(i_num[63:DIV_Q_W]) >= i_den);
                r_cnt  <= 6'(DIV_Q_W);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= ge ? 32'(trial - {1'b0, i_den}) : trial[31:0];
                r_nq  <= {r_nq[DIV_Q_W-2:0], ge};
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_quot = r_nq;
    assign o_stat = '{busy: r_busy, done: r_done, ovf: r_ovf};
endmodule

### src/pmsm_phase_current_integrator_top.sv
// Sequence: an accepted word runs S_OM through S_FIN to S_OUT with inductance set, or
//   goes to S_OUT when inductance is zero (state held); one word in flight at a time.
// Flow control: a result-side stall holds S_OUT and so delays the next word; the
//   shared 34-step divider (two current steps) takes most of each word's time, the
//   shared 32x32 multiplier the rest.
// Reset (i_rst_n, synchronous, low): configuration, currents, back-EMF and phase
//   voltages cleared to zero; no clearing pass.
module pmsm_phase_current_integrator_top #(
    parameter int SINE_TABLE_BITS = pci_pkg::SINE_TABLE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pci_in_if.sink      i_in,
    pci_out_if.source   o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import pci_pkg::*;

    localparam logic [15:0] ANG_MASK =
        16'(((1 << SINE_TABLE_BITS) - 1) << (16 - SINE_TABLE_BITS));

    // sequencer codes
    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_OM   = 5'd1;   // |speed| * pole pairs
    localparam logic [4:0] S_TH   = 5'd2;   // angle * pole pairs
    localparam logic [4:0] S_AMP0 = 5'd3;   // |omega| * Ke, low part
    localparam logic [4:0] S_AMP1 = 5'd4;   // high part
    localparam logic [4:0] S_AMP2 = 5'd5;   // sum partials
    localparam logic [4:0] S_SZ   = 5'd6;   // z*z
    localparam logic [4:0] S_S1   = 5'd7;   // C7*z2
    localparam logic [4:0] S_S2   = 5'd8;
    localparam logic [4:0] S_S3   = 5'd9;
    localparam logic [4:0] S_S4   = 5'd10;  // p*z
    localparam logic [4:0] S_S5   = 5'd11;  // round, amp*|sin| low
    localparam logic [4:0] S_E1   = 5'd12;  // amp*|sin| high
    localparam logic [4:0] S_E2   = 5'd13;  // emf out
    localparam logic [4:0] S_VN   = 5'd14;  // star sum * reciprocal of 3
    localparam logic [4:0] S_VNW  = 5'd15;  // phase voltages
    localparam logic [4:0] S_I0   = 5'd16;  // R*|i|
    localparam logic [4:0] S_I1   = 5'd17;  // drive
    localparam logic [4:0] S_I2   = 5'd18;  // |drive|*dt
    localparam logic [4:0] S_I3   = 5'd19;  // / L
    localparam logic [4:0] S_I4   = 5'd20;
    localparam logic [4:0] S_FIN  = 5'd21;  // phase C current
    localparam logic [4:0] S_OUT  = 5'd22;

    // configuration
    logic [6:0]  r_pp;
    logic [31:0] r_res;
    logic [31:0] r_ind;
    logic [31:0] r_ke;

    logic [4:0]         r_state;
    logic [1:0]         r_ph;
    t_in                r_in;
    logic               r_held;
    logic               r_oneg;
    logic [38:0]        r_om;
    logic [15:0]        r_theta;
    logic [63:0]        r_t;
    logic [46:0]        r_amp;
    logic [30:0]        r_z;
    logic [30:0]        r_z2;
    logic               r_qneg;
    logic [15:0]        r_smag;
    logic               r_vneg;
    logic signed [31:0] r_drive;
    logic signed [31:0] r_emf  [0:2];
    logic signed [31:0] r_pv   [0:2];
    logic signed [31:0] r_amps [0:2];
    t_out               r_out;
    logic               r_out_valid;

    // shared units
    logic [31:0]        mul_a;
    logic [31:0]        mul_b;
    logic [63:0]        mul_prod;
    logic               div_start;
    logic [63:0]        div_num;
    logic [31:0]        div_den;
    logic [DIV_Q_W-1:0] div_q;
    t_div_stat          div_stat;

    pci_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_prod(mul_prod)
    );

    pci_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(div_start),
        .i_num  (div_num),
        .i_den  (div_den),
        .o_quot (div_q),
        .o_stat (div_stat)
    );

    // ---- datapath helpers ----
    logic               cfg_wr;
    logic               accept;
    logic [31:0]        spd_mag;
    logic [15:0]        ang;
    logic [15:0]        ang_q;
    logic [14:0]        z_hi;
    logic [30:0]        z_cur;
    logic [31:0]        poly_p;
    logic [32:0]        sin_rnd;
    logic [15:0]        sin_mag;
    logic [71:0]        amp_full;
    logic [63:0]        emf_full;
    logic signed [33:0] vsum;
    logic [33:0]        vsum_mag;
    logic [31:0]        div3_arg;
    logic [33:0]        vn_mag;
    logic signed [34:0] vn;
    logic               ph_b;
    logic signed [31:0] amps_cur;
    logic [31:0]        amps_mag;
    logic [31:0]        drive_mag;
    logic signed [63:0] drop_s;
    logic [33:0]        step;

    assign cfg_wr = psel && penable && pwrite && pready;
    assign accept = i_in.valid && i_in.ready;

    assign spd_mag = r_in.rotor_speed[31] ? 32'(-r_in.rotor_speed) : r_in.rotor_speed;

    // electrical angle of the current phase, truncated to table resolution
    always_comb begin
        unique case (r_ph)
            2'd1:    ang = r_theta - ANGLE_THIRD;
            2'd2:    ang = r_theta + ANGLE_THIRD;
            default: ang = r_theta;
        endcase
    end
    assign ang_q = ang & ANG_MASK;
    assign z_hi  = ang_q[14] ? 15'(15'd16384 - {1'b0, ang_q[13:0]}) : {1'b0, ang_q[13:0]};
    assign z_cur = {z_hi, 16'b0};

    always_comb begin
        unique case (r_state)
            S_S2:    poly_p = C5 - mul_prod[61:30];
            S_S3:    poly_p = C3 - mul_prod[61:30];
            default: poly_p = C1 - mul_prod[61:30];
        endcase
    end

    assign sin_rnd = {1'b0, mul_prod[61:30]} + 33'd16384;
    assign sin_mag = sin_rnd[30:15];

    assign amp_full = {8'b0, r_t} + {mul_prod[39:0], 32'b0};
    assign emf_full = r_t + {mul_prod[31:0], 32'b0};

    assign vsum = 34'(r_in.terminal_volt_a) + 34'(r_in.terminal_volt_b)
                + 34'(r_in.terminal_volt_c);
    assign vsum_mag = vsum[33] ? 34'(-vsum) : vsum;
    // |sum| <= 3*2^31: split at 2^32, the high bit folds in as 2^32 = 3*THIRD + 1
    assign div3_arg = vsum_mag[31:0] + 32'(vsum_mag[32]);
    assign vn_mag   = 34'(mul_prod[63:33]) + (vsum_mag[32] ? THIRD_OF_2P32 : 34'd0);
    assign vn = r_vneg ? -$signed({1'b0, vn_mag}) : $signed({1'b0, vn_mag});

    assign ph_b      = r_ph[0];
    assign amps_cur  = ph_b ? r_amps[1] : r_amps[0];
    assign amps_mag  = amps_cur[31] ? 32'(-amps_cur) : amps_cur;
    assign drive_mag = r_drive[31] ? 32'(-r_drive) : r_drive;
    assign drop_s    = amps_cur[31] ? -$signed(64'(mul_prod[63:16]))
                                    : $signed(64'(mul_prod[63:16]));
    // clamp of the current step to 2^33
    assign step = (div_stat.ovf || div_q > 34'h200000000) ? 34'h200000000 : div_q;

    // operand selection for the shared units
    always_comb begin
        mul_a     = '0;
        mul_b     = '0;
        div_start = 1'b0;
        div_num   = '0;
        div_den   = r_ind;
        unique case (r_state)
            S_OM: begin
                mul_a = spd_mag;
                mul_b = 32'(r_pp);
            end
            S_TH: begin
                mul_a = 32'(r_in.rotor_angle);
                mul_b = 32'(r_pp);
            end
            S_AMP0: begin
                mul_a = r_om[31:0];
                mul_b = r_ke;
            end
            S_AMP1: begin
                mul_a = 32'(r_om[38:32]);
                mul_b = r_ke;
            end
            S_SZ: begin
                mul_a = 32'(z_cur);
                mul_b = 32'(z_cur);
            end
            S_S1: begin
                mul_a = C7;
                mul_b = 32'(mul_prod[60:30]);
            end
            S_S2, S_S3: begin
                mul_a = poly_p;
                mul_b = 32'(r_z2);
            end
            S_S4: begin
                mul_a = poly_p;
                mul_b = 32'(r_z);
            end
            S_S5: begin
                mul_a = r_amp[31:0];
                mul_b = 32'(sin_mag);
            end
            S_E1: begin
                mul_a = 32'(r_amp[46:32]);
                mul_b = 32'(r_smag);
            end
            S_VN: begin
                mul_a = div3_arg;
                mul_b = RECIP3;
            end
            S_I0: begin
                mul_a = r_res;
                mul_b = amps_mag;
            end
            S_I2: begin
                mul_a = drive_mag;
                mul_b = r_in.time_step;
            end
            S_I3: begin
                div_start = 1'b1;
                div_num   = mul_prod;
            end
            default: begin
            end
        endcase
    end

    // ---- sequencer and state ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ph        <= '0;
            r_out_valid <= 1'b0;
            r_held      <= 1'b0;
            r_pp        <= '0;
            r_res       <= '0;
            r_ind       <= '0;
            r_ke        <= '0;
            for (int k = 0; k < 3; k++) begin
                r_emf[k]  <= '0;
                r_pv[k]   <= '0;
                r_amps[k] <= '0;
            end
        end else begin
            if (cfg_wr) begin
                unique case (paddr[3:2])
                    REG_POLE_PAIRS: r_pp  <= pwdata[6:0];
                    REG_RESISTANCE: r_res <= pwdata;
                    REG_INDUCTANCE: r_ind <= pwdata;
                    REG_EMF_CONST:  r_ke  <= pwdata;
                endcase
            end

            // in S_OUT a taken word is replaced below
            if (o_out.ready && r_state != S_OUT) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_in    <= i_in.data;
                        r_held  <= (r_ind == 32'd0);
                        r_ph    <= '0;
                        r_state <= (r_ind == 32'd0) ? S_OUT : S_OM;
                    end
                end
                S_OM: begin
                    r_oneg  <= r_in.rotor_speed[31] && (r_pp != 7'd0);
                    r_state <= S_TH;
                end
                S_TH: begin
                    r_om    <= mul_prod[38:0];
                    r_state <= S_AMP0;
                end
                S_AMP0: begin
                    r_theta <= mul_prod[15:0];
                    r_state <= S_AMP1;
                end
                S_AMP1: begin
                    r_t     <= mul_prod;
                    r_state <= S_AMP2;
                end
                S_AMP2: begin
                    r_amp   <= amp_full[70:24];
                    r_state <= S_SZ;
                end
                S_SZ: begin
                    r_z     <= z_cur;
                    r_qneg  <= ang_q[15];
                    r_state <= S_S1;
                end
                S_S1: begin
                    r_z2    <= mul_prod[60:30];
                    r_state <= S_S2;
                end
                S_S2: r_state <= S_S3;
                S_S3: r_state <= S_S4;
                S_S4: r_state <= S_S5;
                S_S5: begin
                    r_smag  <= sin_mag;
                    r_state <= S_E1;
                end
                S_E1: begin
                    r_t     <= mul_prod;
                    r_state <= S_E2;
                end
                S_E2: begin
                    // sign: minus omega sign times sine sign
                    r_emf[r_ph] <= signed_sat(r_oneg != (!r_qneg && r_smag != 16'd0),
                                              emf_full[62:15]);
                    if (r_ph == 2'd2) begin
                        r_state <= S_VN;
                    end else begin
                        r_ph    <= r_ph + 2'd1;
                        r_state <= S_SZ;
                    end
                end
                S_VN: begin
                    r_vneg  <= vsum[33];
                    r_state <= S_VNW;
                end
                S_VNW: begin
                    r_pv[0] <= sat32(64'(r_in.terminal_volt_a) - 64'(vn));
                    r_pv[1] <= sat32(64'(r_in.terminal_volt_b) - 64'(vn));
                    r_pv[2] <= sat32(64'(r_in.terminal_volt_c) - 64'(vn));
                    r_ph    <= '0;
                    r_state <= S_I0;
                end
                S_I0: r_state <= S_I1;
                S_I1: begin
                    r_drive <= sat32(64'(ph_b ? r_pv[1] : r_pv[0]) - drop_s
                                     - 64'(ph_b ? r_emf[1] : r_emf[0]));
                    r_state <= S_I2;
                end
                S_I2: r_state <= S_I3;
                S_I3: r_state <= S_I4;
                S_I4: begin
                    if (div_stat.done) begin
                        if (ph_b) begin
                            r_amps[1] <= sat32(r_drive[31] ? 64'(amps_cur) - 64'(step)
                                                           : 64'(amps_cur) + 64'(step));
                            r_state   <= S_FIN;
                        end else begin
                            r_amps[0] <= sat32(r_drive[31] ? 64'(amps_cur) - 64'(step)
                                                           : 64'(amps_cur) + 64'(step));
                            r_ph      <= 2'd1;
                            r_state   <= S_I0;
                        end
                    end
                end
                S_FIN: begin
                    r_amps[2] <= sat32(-(64'(r_amps[0]) + 64'(r_amps[1])));
                    r_state   <= S_OUT;
                end
                S_OUT: begin
                    // output word register must be free or being taken
                    if (!r_out_valid || o_out.ready) begin
                        r_out.current_a      <= r_amps[0];
                        r_out.current_b      <= r_amps[1];
                        r_out.current_c      <= r_amps[2];
                        r_out.emf_a          <= r_emf[0];
                        r_out.emf_b          <= r_emf[1];
                        r_out.emf_c          <= r_emf[2];
                        r_out.neutral_volt_a <= r_pv[0];
                        r_out.neutral_volt_b <= r_pv[1];
                        r_out.neutral_volt_c <= r_pv[2];
                        r_out.held           <= r_held;
                        r_out_valid          <= 1'b1;
                        r_state              <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_in.ready  = (r_state == S_IDLE);
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;
    assign pready      = 1'b1;

    always_comb begin
        unique case (paddr[3:2])
            REG_POLE_PAIRS: prdata = 32'(r_pp);
            REG_RESISTANCE: prdata = r_res;
            REG_INDUCTANCE: prdata = r_ind;
            REG_EMF_CONST:  prdata = r_ke;
        endcase
    end

`ifndef SYNTHESIS
    a_run_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_ind != 32'd0) |=> (r_state == S_OM))
        else $error("accepted word did not start the step");

    a_div_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider restarted while busy");

    a_idle_div_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !div_stat.busy)
        else $error("divider busy while idle");

    a_held_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_ind == 32'd0) |=> (r_state == S_OUT && r_held))
        else $error("zero inductance did not hold state");
`endif
endmodule
